// ----- src/stereo_feedback_echo_macros.svh -----
// assertion macros for the stereo feedback echo
`ifndef STEREO_FEEDBACK_ECHO_MACROS_SVH
`define STEREO_FEEDBACK_ECHO_MACROS_SVH
`ifndef SYNTH
`define SFE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define SFE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define SFE_ASSERT(lbl, prop, msg)
`define SFE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- src/sfe_pkg.sv -----
// constants and helpers for the stereo feedback echo
`timescale 1ns / 1ps
package sfe_pkg;
    localparam int SB           = 24;
    localparam int SAMPLE_RATE  = 44100;
    localparam int LINE_DEPTH_DEF = 32768;

    localparam int UNITY      = 65536;
    localparam int SEC_BASE   = 6554;
    localparam int SEC_SLOPE  = 31457;
    localparam int FB_SLOPE   = 55706;
    localparam int WET_SLOPE  = 42598;
    localparam int TONE_BASE  = 39322;
    localparam int TONE_SLOPE = 22938;
    localparam int COEF_BASE  = 60948;
    localparam int COEF_SLOPE = 39977;
    localparam int STEP_BASE  = UNITY - COEF_BASE;
    localparam int GLIDE      = 2621;
    localparam int SILENCE    = 168;

    localparam int MA_W  = 34;
    localparam int MB_W  = 18;
    localparam int P_W   = MA_W + MB_W;
    localparam int SAT_W = 28;

    localparam logic REG_AMOUNT_TARGET = 1'b0;
    localparam logic REG_SEND_LEVEL    = 1'b1;

    function automatic logic signed [SB-1:0] sat_sample(input logic signed [SAT_W-1:0] x);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'((longint'(1) <<< (SB - 1)) - 1);
        lo = -hi - SAT_W'(1);
        if (x > hi) return hi[SB-1:0];
        if (x < lo) return lo[SB-1:0];
        return x[SB-1:0];
    endfunction

    function automatic logic [16:0] clamp_unity(input logic [16:0] v);
        return (v > 17'(UNITY)) ? 17'(UNITY) : v;
    endfunction
endpackage

// ----- src/stereo_feedback_echo.sv -----
// stereo feedback echo: sequencer around one shared multiplier and a delay memory
// active samples read the taps, compute each channel and write the line; bypass skips this
// a first-of-block sample runs the amount glide, then rederives gains unless bypassed
// new samples are taken only after the last one reaches the output; the multiplier is shared
// reset: synchronous active low; line contents read as zero until written (fill tracking)
`timescale 1ns / 1ps
`include "stereo_feedback_echo_macros.svh"
module stereo_feedback_echo
    import sfe_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_first_of_block,
    input  logic signed [SB-1:0] s_dry_left,
    input  logic signed [SB-1:0] s_dry_right,
    input  logic signed [SB-1:0] s_send_left_in,
    input  logic signed [SB-1:0] s_send_right_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [SB-1:0] m_out_left,
    output logic signed [SB-1:0] m_out_right,
    output logic signed [SB-1:0] m_send_left_out,
    output logic signed [SB-1:0] m_send_right_out
);
    localparam int PW = $clog2(LINE_DEPTH);
    localparam longint DQ0 = longint'(SEC_BASE) * SAMPLE_RATE;
    localparam int WHOLE0_RAW = int'(DQ0 >> 16);
    localparam int WHOLE0 = (WHOLE0_RAW < 1) ? 1 :
                            ((WHOLE0_RAW >= LINE_DEPTH - 1) ? LINE_DEPTH - 2 : WHOLE0_RAW);
    localparam int FRAC0 = int'(DQ0 % 65536);
    localparam int STEP0 = STEP_BASE +
                           int'((longint'(TONE_BASE) * COEF_SLOPE + 32768) >> 16);

    typedef enum logic [22:0] {
        ST_IDLE   = 23'd1 << 0,
        ST_SM_MUL = 23'd1 << 1,
        ST_SM_UPD = 23'd1 << 2,
        ST_D_SEC  = 23'd1 << 3,
        ST_D_FB   = 23'd1 << 4,
        ST_D_WET  = 23'd1 << 5,
        ST_D_TONE = 23'd1 << 6,
        ST_D_DLY  = 23'd1 << 7,
        ST_D_COEF = 23'd1 << 8,
        ST_D_STEP = 23'd1 << 9,
        ST_CHECK  = 23'd1 << 10,
        ST_P_RA   = 23'd1 << 11,
        ST_P_RB   = 23'd1 << 12,
        ST_P_RD   = 23'd1 << 13,
        ST_C_INTP = 23'd1 << 14,
        ST_C_D    = 23'd1 << 15,
        ST_C_TMUL = 23'd1 << 16,
        ST_C_TONE = 23'd1 << 17,
        ST_C_WET  = 23'd1 << 18,
        ST_C_FB   = 23'd1 << 19,
        ST_C_SEND = 23'd1 << 20,
        ST_P_WR   = 23'd1 << 21,
        ST_FIN    = 23'd1 << 22
    } state_t;

    state_t state_reg, state_next;

    logic [16:0] target_reg, slev_reg;
    logic [23:0] amt_reg;
    logic        bypass_reg;
    logic [PW-1:0] whole_reg, wp_reg;
    logic        wrapped_reg;
    logic [15:0] frac_reg, fb_reg, wet_reg, step_reg, tmp_reg;
    logic signed [31:0] tone_l_reg, tone_r_reg;
    logic        ch_reg;
    logic signed [SB-1:0] dry_l_reg, dry_r_reg, snd_l_reg, snd_r_reg;
    logic [2*SB-1:0] a_reg, b_reg, rdata_reg;
    logic        rvalid_reg;
    logic signed [SB-1:0] d_reg, w_reg, wl_reg, wr_reg;
    logic signed [SB-1:0] res_l_reg, res_r_reg, res_sl_reg, res_sr_reg;
    logic        m_valid_reg;
    logic signed [SB-1:0] m_l_reg, m_r_reg, m_sl_reg, m_sr_reg;
    logic signed [P_W-1:0] prod_reg;

    logic [2*SB-1:0] line_mem [LINE_DEPTH];

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [P_W-1:0]  r16, r24;
    logic [16:0] tgt_c, slev_c;
    logic [24:0] t24;
    logic signed [25:0] sm_diff, sm_mag;
    logic signed [27:0] sm_cur;
    logic [23:0] sm_new;
    logic [PW:0] ra_wide;
    logic [PW-1:0] ra, rb, rd_addr;
    logic [15:0] dq_whole;
    logic [PW-1:0] whole_clamped;
    logic signed [SB-1:0] a_c, b_c, dry_c, snd_c;
    logic signed [31:0] tone_c;
    logic mem_we;
    logic cfg_wr;

    // apb port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    always_comb begin
        case (paddr[2])
            REG_AMOUNT_TARGET: prdata = {15'd0, target_reg};
            REG_SEND_LEVEL:    prdata = {15'd0, slev_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_out_left       = m_l_reg;
    assign m_out_right      = m_r_reg;
    assign m_send_left_out  = m_sl_reg;
    assign m_send_right_out = m_sr_reg;

    assign tgt_c  = clamp_unity(target_reg);
    assign slev_c = clamp_unity(slev_reg);
    assign t24    = {tgt_c, 8'd0};

    assign r16 = (prod_reg + P_W'(32768)) >>> 16;
    assign r24 = (prod_reg + P_W'(8388608)) >>> 24;

    // amount glide
    always_comb begin
        sm_diff = $signed({1'b0, t24}) - $signed({2'b00, amt_reg});
        sm_mag  = sm_diff[25] ? -sm_diff : sm_diff;
        if (sm_diff[25]) begin
            sm_cur = $signed({4'd0, amt_reg}) - r16[27:0];
        end else begin
            sm_cur = $signed({4'd0, amt_reg}) + r16[27:0];
        end
        if (sm_cur < 0) begin
            sm_new = 24'd0;
        end else if (sm_cur > 28'sh0FFFFFF) begin
            sm_new = 24'hFFFFFF;
        end else begin
            sm_new = sm_cur[23:0];
        end
    end

    // tap addresses, modulo line depth
    always_comb begin
        ra_wide = {1'b0, wp_reg} - {1'b0, whole_reg};
        if (ra_wide[PW]) begin
            ra_wide = ra_wide + (PW+1)'(LINE_DEPTH);
        end
        ra = ra_wide[PW-1:0];
        rb = (ra == '0) ? PW'(LINE_DEPTH - 1) : ra - PW'(1);
        rd_addr = (state_reg == ST_P_RB) ? rb : ra;
    end

    always_comb begin
        dq_whole = prod_reg[31:16];
        if (dq_whole == 16'd0) begin
            whole_clamped = PW'(1);
        end else if (32'(dq_whole) >= 32'(LINE_DEPTH - 1)) begin
            whole_clamped = PW'(LINE_DEPTH - 2);
        end else begin
            whole_clamped = PW'(dq_whole);
        end
    end

    assign a_c    = ch_reg ? a_reg[SB-1:0] : a_reg[2*SB-1:SB];
    assign b_c    = ch_reg ? b_reg[SB-1:0] : b_reg[2*SB-1:SB];
    assign dry_c  = ch_reg ? dry_r_reg : dry_l_reg;
    assign snd_c  = ch_reg ? snd_r_reg : snd_l_reg;
    assign tone_c = ch_reg ? tone_r_reg : tone_l_reg;
    assign mem_we = (state_reg == ST_P_WR);

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SM_MUL: begin
                mul_a = MA_W'(sm_mag);
                mul_b = MB_W'(GLIDE);
            end
            ST_D_SEC: begin
                mul_a = $signed({18'd0, amt_reg[23:8]});
                mul_b = MB_W'(SEC_SLOPE);
            end
            ST_D_FB: begin
                mul_a = $signed({18'd0, amt_reg[23:8]});
                mul_b = MB_W'(FB_SLOPE);
            end
            ST_D_WET: begin
                mul_a = $signed({18'd0, amt_reg[23:8]});
                mul_b = MB_W'(WET_SLOPE);
            end
            ST_D_TONE: begin
                mul_a = $signed({18'd0, amt_reg[23:8]});
                mul_b = MB_W'(TONE_SLOPE);
            end
            ST_D_DLY: begin
                mul_a = $signed({18'd0, tmp_reg});
                mul_b = MB_W'(SAMPLE_RATE);
            end
            ST_D_COEF: begin
                mul_a = $signed({18'd0, tmp_reg});
                mul_b = MB_W'(COEF_SLOPE);
            end
            ST_C_INTP: begin
                mul_a = MA_W'($signed({b_c[SB-1], b_c}) - $signed({a_c[SB-1], a_c}));
                mul_b = $signed({2'b00, frac_reg});
            end
            ST_C_TMUL: begin
                mul_a = MA_W'($signed({d_reg[SB-1], d_reg, 8'd0})
                            - $signed({tone_c[31], tone_c}));
                mul_b = $signed({2'b00, step_reg});
            end
            ST_C_TONE: begin
                mul_a = MA_W'(d_reg);
                mul_b = $signed({2'b00, wet_reg});
            end
            ST_C_WET: begin
                mul_a = MA_W'(tone_c);
                mul_b = $signed({2'b00, fb_reg});
            end
            ST_C_FB: begin
                mul_a = MA_W'(w_reg);
                mul_b = $signed({1'b0, slev_c});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = s_first_of_block ? ST_SM_MUL : ST_CHECK;
            ST_SM_MUL: state_next = ST_SM_UPD;
            ST_SM_UPD: state_next = ((sm_new < 24'(SILENCE)) && (t24 < 25'(SILENCE)))
                                    ? ST_CHECK : ST_D_SEC;
            ST_D_SEC:  state_next = ST_D_FB;
            ST_D_FB:   state_next = ST_D_WET;
            ST_D_WET:  state_next = ST_D_TONE;
            ST_D_TONE: state_next = ST_D_DLY;
            ST_D_DLY:  state_next = ST_D_COEF;
            ST_D_COEF: state_next = ST_D_STEP;
            ST_D_STEP: state_next = ST_CHECK;
            ST_CHECK:  state_next = bypass_reg ? ST_FIN : ST_P_RA;
            ST_P_RA:   state_next = ST_P_RB;
            ST_P_RB:   state_next = ST_P_RD;
            ST_P_RD:   state_next = ST_C_INTP;
            ST_C_INTP: state_next = ST_C_D;
            ST_C_D:    state_next = ST_C_TMUL;
            ST_C_TMUL: state_next = ST_C_TONE;
            ST_C_TONE: state_next = ST_C_WET;
            ST_C_WET:  state_next = ST_C_FB;
            ST_C_FB:   state_next = ST_C_SEND;
            ST_C_SEND: state_next = ch_reg ? ST_P_WR : ST_C_INTP;
            ST_P_WR:   state_next = ST_FIN;
            ST_FIN:    if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // delay line memory, both channels side by side
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[wp_reg] <= {wl_reg, wr_reg};
        end
        rdata_reg <= line_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE: begin
                dry_l_reg <= s_dry_left;
                dry_r_reg <= s_dry_right;
                snd_l_reg <= s_send_left_in;
                snd_r_reg <= s_send_right_in;
            end
            ST_CHECK: begin
                res_l_reg  <= dry_l_reg;
                res_r_reg  <= dry_r_reg;
                res_sl_reg <= snd_l_reg;
                res_sr_reg <= snd_r_reg;
            end
            ST_P_RB: a_reg <= rvalid_reg ? rdata_reg : '0;
            ST_P_RD: b_reg <= rvalid_reg ? rdata_reg : '0;
            ST_C_D:  d_reg <= a_c + r16[SB-1:0];
            ST_C_WET: w_reg <= r16[SB-1:0];
            ST_C_FB: begin
                if (ch_reg) begin
                    wr_reg <= sat_sample(SAT_W'(dry_c) + r24[SAT_W-1:0]);
                end else begin
                    wl_reg <= sat_sample(SAT_W'(dry_c) + r24[SAT_W-1:0]);
                end
            end
            ST_C_SEND: begin
                if (ch_reg) begin
                    res_r_reg  <= sat_sample(SAT_W'(dry_c) + SAT_W'(w_reg));
                    res_sr_reg <= sat_sample(SAT_W'(snd_c) + r16[SAT_W-1:0]);
                end else begin
                    res_l_reg  <= sat_sample(SAT_W'(dry_c) + SAT_W'(w_reg));
                    res_sl_reg <= sat_sample(SAT_W'(snd_c) + r16[SAT_W-1:0]);
                end
            end
            ST_D_FB:  tmp_reg <= 16'(SEC_BASE) + r16[15:0];
            ST_D_DLY: tmp_reg <= 16'(TONE_BASE) - r16[15:0];
            default: begin
            end
        endcase
        // unwritten entries read as zero
        rvalid_reg <= wrapped_reg || (rd_addr < wp_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            target_reg  <= '0;
            slev_reg    <= '0;
            amt_reg     <= '0;
            bypass_reg  <= 1'b1;
            whole_reg   <= PW'(WHOLE0);
            frac_reg    <= 16'(FRAC0);
            fb_reg      <= '0;
            wet_reg     <= '0;
            step_reg    <= 16'(STEP0);
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
            tone_l_reg  <= '0;
            tone_r_reg  <= '0;
            ch_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                case (paddr[2])
                    REG_AMOUNT_TARGET: target_reg <= pwdata[16:0];
                    REG_SEND_LEVEL:    slev_reg   <= pwdata[16:0];
                    default: begin
                    end
                endcase
            end
            case (state_reg)
                ST_SM_UPD: begin
                    amt_reg    <= sm_new;
                    bypass_reg <= (sm_new < 24'(SILENCE)) && (t24 < 25'(SILENCE));
                end
                ST_D_WET:  fb_reg  <= r16[15:0];
                ST_D_TONE: wet_reg <= r16[15:0];
                ST_D_COEF: begin
                    whole_reg <= whole_clamped;
                    frac_reg  <= prod_reg[15:0];
                end
                ST_D_STEP: step_reg <= 16'(STEP_BASE) + r16[15:0];
                ST_P_RD:   ch_reg <= 1'b0;
                ST_C_TONE: begin
                    if (ch_reg) begin
                        tone_r_reg <= tone_c + r16[31:0];
                    end else begin
                        tone_l_reg <= tone_c + r16[31:0];
                    end
                end
                ST_C_SEND: ch_reg <= ~ch_reg;
                ST_P_WR: begin
                    if (wp_reg == PW'(LINE_DEPTH - 1)) begin
                        wp_reg      <= '0;
                        wrapped_reg <= 1'b1;
                    end else begin
                        wp_reg <= wp_reg + PW'(1);
                    end
                end
                default: begin
                end
            endcase
            if (state_reg == ST_FIN && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result registers load only when the output is free or the previous transaction leaves
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && (!m_valid_reg || m_ready)) begin
            m_l_reg  <= res_l_reg;
            m_r_reg  <= res_r_reg;
            m_sl_reg <= res_sl_reg;
            m_sr_reg <= res_sr_reg;
        end
    end

    `SFE_ASSERT(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "accepted while busy")
    `SFE_ASSERT(a_whole_range, whole_reg != '0 && whole_reg <= PW'(LINE_DEPTH - 2), "delay range")
    `SFE_ASSERT(a_tap_not_wp, (state_reg == ST_P_RA || state_reg == ST_P_RB) |-> rd_addr != wp_reg, "tap hits write pointer")
    `SFE_ASSERT(a_no_write_bypass, mem_we |-> !bypass_reg, "line written in bypass")
endmodule
